// ===== hdl/sgp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sgp_pkg
// Shared types, codes and defaults for the shared group-ID pool.
// ----------------------------------------------------------------------------
package sgp_pkg;

    localparam int NUM_GROUPS_DEF = 64;
    localparam int NUM_SUBS_DEF   = 16;

    localparam logic [1:0] OP_GROUP_GET = 2'd0;
    localparam logic [1:0] OP_GROUP_PUT = 2'd1;
    localparam logic [1:0] OP_SUB_GET   = 2'd2;
    localparam logic [1:0] OP_SUB_PUT   = 2'd3;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NO_SPACE  = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;

    typedef struct packed {
        logic [1:0]  op;
        logic [15:0] service_id;
        logic [9:0]  share_limit;
        logic [5:0]  group_in;
        logic [3:0]  sub_in;
    } req_t;

    typedef struct packed {
        logic [1:0] status;
        logic [5:0] group_out;
        logic [3:0] sub_out;
    } rsp_t;

    // Controller to datapath.
    typedef struct packed {
        logic load;
        logic scan;
        logic finish_get;
        logic rd;
        logic exec;
    } ctl_cmd_t;

    // Datapath to controller.
    typedef struct packed {
        logic hit;
        logic scan_last;
        logic is_get;
    } dp_stat_t;

endpackage

// ===== hdl/sgp_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sgp_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module sgp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hdl/sgp_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sgp_ctrl
// Sequencer for the group-ID pool: scan for group get, read-modify-write
// for the other operations.
// ----------------------------------------------------------------------------
module sgp_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  sgp_pkg::dp_stat_t stat,
    output sgp_pkg::ctl_cmd_t cmd,
    output logic             busy
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SCAN  = 3'd1;
    localparam logic [2:0] S_DRAIN = 3'd2;
    localparam logic [2:0] S_READ  = 3'd3;
    localparam logic [2:0] S_EXEC  = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = stat.is_get ? S_SCAN : S_READ;
                end
            end
            S_SCAN:
            begin
                if (stat.hit)
                begin
                    cmd.finish_get = 1'b1;
                    state_next     = S_IDLE;
                end
                else
                begin
                    cmd.scan = 1'b1;
                    if (stat.scan_last)
                    begin
                        state_next = S_DRAIN;
                    end
                end
            end
            S_DRAIN:
            begin
                cmd.finish_get = 1'b1;
                state_next     = S_IDLE;
            end
            S_READ:
            begin
                cmd.rd     = 1'b1;
                state_next = S_EXEC;
            end
            S_EXEC:
            begin
                cmd.exec   = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != S_IDLE);

endmodule

// ===== hdl/sgp_dpath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sgp_dpath
// Entry table, valid bits, scan counter and result register.
// ----------------------------------------------------------------------------
module sgp_dpath #(
    parameter int NUM_GROUPS = sgp_pkg::NUM_GROUPS_DEF,
    parameter int NUM_SUBS   = sgp_pkg::NUM_SUBS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  sgp_pkg::req_t     request,
    input  sgp_pkg::ctl_cmd_t cmd,
    output sgp_pkg::dp_stat_t stat,
    output logic              done,
    output sgp_pkg::rsp_t     result
);

    localparam int AW     = $clog2(NUM_GROUPS);
    localparam int U_LSB  = NUM_SUBS;
    localparam int L_LSB  = NUM_SUBS + 10;
    localparam int S_LSB  = NUM_SUBS + 20;
    localparam int EW     = NUM_SUBS + 36;
    localparam logic [10:0] NG  = 11'(NUM_GROUPS);
    localparam logic [6:0]  NS  = 7'(NUM_SUBS);

    sgp_pkg::req_t req_reg;
    logic [NUM_GROUPS-1:0] valid_reg;
    logic [AW-1:0] cnt_reg;
    logic [AW-1:0] cmp_idx_reg;
    logic          cmp_vld_reg;
    logic          free_found_reg;
    logic [AW-1:0] free_idx_reg;
    logic          done_reg;
    sgp_pkg::rsp_t result_reg;

    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [EW-1:0] wr_data;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic [EW-1:0] rd_data;

    logic [15:0]         e_svc;
    logic [9:0]          e_lim;
    logic [9:0]          e_users;
    logic [NUM_SUBS-1:0] e_map;
    logic [9:0]          users_dec;
    logic [NUM_SUBS-1:0] low_zero;
    logic [NUM_SUBS-1:0] clr_mask;
    logic [3:0]          sub_idx;
    logic [AW-1:0]       gaddr;
    logic                live;
    logic                hit;

    sgp_ram #(
        .WIDTH (EW),
        .DEPTH (NUM_GROUPS)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign e_map   = rd_data[NUM_SUBS-1:0];
    assign e_users = rd_data[U_LSB +: 10];
    assign e_lim   = rd_data[L_LSB +: 10];
    assign e_svc   = rd_data[S_LSB +: 16];
    assign users_dec = e_users - 10'd1;

    assign gaddr = AW'(req_reg.group_in);
    assign live  = (req_reg.group_in != 6'd0) && ({5'b0, req_reg.group_in} < NG)
                   && valid_reg[gaddr];

    assign hit = cmp_vld_reg && valid_reg[cmp_idx_reg] && (e_svc == req_reg.service_id)
                 && (e_lim == req_reg.share_limit) && (e_users < e_lim);

    // Lowest clear bit of the sub-ID map, one-hot.
    assign low_zero = ~e_map & (e_map + NUM_SUBS'(1));

    always_comb
    begin
        sub_idx  = '0;
        clr_mask = '0;
        for (int i = 0; i < NUM_SUBS; i++)
        begin
            if (low_zero[i])
            begin
                sub_idx = 4'(i);
            end
            clr_mask[i] = (7'(i) == {3'b0, req_reg.sub_in});
        end
    end

    assign stat.hit       = hit;
    assign stat.scan_last = (cnt_reg == AW'(NUM_GROUPS - 1));
    assign stat.is_get    = (request.op == sgp_pkg::OP_GROUP_GET);

    assign rd_en   = cmd.scan || cmd.rd;
    assign rd_addr = cmd.scan ? cnt_reg : gaddr;

    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = gaddr;
        wr_data = rd_data;
        if (cmd.finish_get)
        begin
            if (hit)
            begin
                wr_en   = 1'b1;
                wr_addr = cmp_idx_reg;
                wr_data[U_LSB +: 10] = e_users + 10'd1;
            end
            else if (free_found_reg)
            begin
                wr_en   = 1'b1;
                wr_addr = free_idx_reg;
                wr_data = {req_reg.service_id, req_reg.share_limit, 10'd1,
                           {NUM_SUBS{1'b0}}};
            end
        end
        else if (cmd.exec && live)
        begin
            case (req_reg.op)
                sgp_pkg::OP_GROUP_PUT:
                begin
                    wr_en = 1'b1;
                    wr_data[U_LSB +: 10] = users_dec;
                end
                sgp_pkg::OP_SUB_GET:
                begin
                    wr_en = 1'b1;
                    wr_data[NUM_SUBS-1:0] = e_map | low_zero;
                end
                default:
                begin
                    wr_en = ({3'b0, req_reg.sub_in} < NS);
                    wr_data[NUM_SUBS-1:0] = e_map & ~clr_mask;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_reg <= request;
        end
        if (cmd.scan)
        begin
            cmp_idx_reg <= cnt_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg      <= '0;
            cnt_reg        <= '0;
            cmp_vld_reg    <= 1'b0;
            free_found_reg <= 1'b0;
            free_idx_reg   <= '0;
            done_reg       <= 1'b0;
            result_reg     <= '0;
        end
        else
        begin
            done_reg <= cmd.finish_get || cmd.exec;
            if (cmd.load)
            begin
                cnt_reg        <= AW'(1);
                cmp_vld_reg    <= 1'b0;
                free_found_reg <= 1'b0;
            end
            else if (cmd.scan)
            begin
                cnt_reg     <= cnt_reg + AW'(1);
                cmp_vld_reg <= 1'b1;
                if (!free_found_reg && !valid_reg[cnt_reg])
                begin
                    free_found_reg <= 1'b1;
                    free_idx_reg   <= cnt_reg;
                end
            end
            if (cmd.finish_get)
            begin
                result_reg <= '0;
                if (hit)
                begin
                    result_reg.group_out <= 6'(cmp_idx_reg);
                end
                else if (free_found_reg)
                begin
                    valid_reg[free_idx_reg] <= 1'b1;
                    result_reg.group_out    <= 6'(free_idx_reg);
                end
                else
                begin
                    result_reg.status <= sgp_pkg::ST_NO_SPACE;
                end
            end
            if (cmd.exec)
            begin
                result_reg <= '0;
                case (req_reg.op)
                    sgp_pkg::OP_GROUP_PUT:
                    begin
                        if (!live)
                        begin
                            result_reg.status <= sgp_pkg::ST_NOT_FOUND;
                        end
                        else if (users_dec == 10'd0)
                        begin
                            valid_reg[gaddr] <= 1'b0;
                        end
                    end
                    sgp_pkg::OP_SUB_GET:
                    begin
                        if (live)
                        begin
                            if (low_zero == '0)
                            begin
                                result_reg.status <= sgp_pkg::ST_NO_SPACE;
                            end
                            else
                            begin
                                result_reg.sub_out <= sub_idx;
                            end
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

// ===== hdl/shared_group_id_pool_with_sub_ids.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shared_group_id_pool_with_sub_ids
// Reference-counted group-ID allocator with per-group sub-ID bitmaps.
// ----------------------------------------------------------------------------
// A request word is taken when start is high and busy is low. Its result
// word appears on result, marked by done for a single cycle, and the
// receiver cannot stall it. A group get walks the entry table one entry per
// cycle through the single RAM read port, stopping early on a match; put,
// sub-ID get and sub-ID put read the addressed entry once. Busy stays high
// until the cycle in which done is raised.
module shared_group_id_pool_with_sub_ids #(
    parameter int NUM_GROUPS = sgp_pkg::NUM_GROUPS_DEF,
    parameter int NUM_SUBS   = sgp_pkg::NUM_SUBS_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    output logic          busy,
    input  sgp_pkg::req_t request,
    output logic          done,
    output sgp_pkg::rsp_t result
);

    sgp_pkg::ctl_cmd_t cmd;
    sgp_pkg::dp_stat_t stat;

    // The controller sequences the scan and the read-modify-write steps.
    sgp_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy)
    );

    // The datapath owns the entry RAM, the valid bits and the result word.
    sgp_dpath #(
        .NUM_GROUPS (NUM_GROUPS),
        .NUM_SUBS   (NUM_SUBS)
    ) u_dpath (
        .clk     (clk),
        .rst_n   (rst_n),
        .request (request),
        .cmd     (cmd),
        .stat    (stat),
        .done    (done),
        .result  (result)
    );

    // A result word is only shown once the controller has gone idle.
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result word shown while busy");

    // An accepted request always makes the block busy next cycle.
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted request did not start work");

    // A result is produced only after a busy period ends.
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result word without a request");

    // Status never carries the unused code.
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (result.status == sgp_pkg::ST_OK || result.status == sgp_pkg::ST_NO_SPACE
                  || result.status == sgp_pkg::ST_NOT_FOUND))
        else $error("bad status code");

endmodule

// ===== sim/shared_group_id_pool_with_sub_ids_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shared_group_id_pool_with_sub_ids_test
// Self-checking bench for the shared group-ID pool with sub-ID bitmaps.
// ----------------------------------------------------------------------------
// Request words are driven through the start/busy handshake. A scoreboard
// class keeps its own copy of the entry table, predicts the result word of
// every accepted request and compares each done-marked result word with the
// oldest prediction, field by field.
module shared_group_id_pool_with_sub_ids_test;

    localparam int NGRP = sgp_pkg::NUM_GROUPS_DEF;
    localparam int NSUB = sgp_pkg::NUM_SUBS_DEF;
    localparam int IDLE_LIMIT = 2000;

    // Scoreboard: a mirror of the pool state plus a queue of predicted words.
    class pool_scoreboard;
        bit            live [NGRP];
        bit [15:0]     svc [NGRP];
        bit [9:0]      lim [NGRP];
        bit [9:0]      users [NGRP];
        bit [NSUB-1:0] subs [NGRP];
        sgp_pkg::rsp_t pending [$];
        int            errors;
        int            checked;

        function new();
            for (int i = 0; i < NGRP; i++)
            begin
                live[i] = 1'b0;
                subs[i] = '0;
            end
            errors = 0;
            checked = 0;
        endfunction

        function bit is_live(bit [5:0] g);
            return g != 6'd0 && live[g];
        endfunction

        // Note an accepted request word and push its predicted result word.
        function void note_request(sgp_pkg::req_t r);
            sgp_pkg::rsp_t p;
            bit found;
            p = '0;
            p.status = sgp_pkg::ST_OK;
            found = 1'b0;
            case (r.op)
                sgp_pkg::OP_GROUP_GET:
                begin
                    // First try to share an existing group with spare room.
                    for (int i = 1; i < NGRP && !found; i++)
                        if (live[i] && svc[i] == r.service_id &&
                            lim[i] == r.share_limit && users[i] < lim[i])
                        begin
                            users[i] = 10'(users[i] + 10'd1);
                            p.group_out = 6'(i);
                            found = 1'b1;
                        end
                    for (int i = 1; i < NGRP && !found; i++)
                        if (!live[i])
                        begin
                            live[i] = 1'b1;
                            svc[i] = r.service_id;
                            lim[i] = r.share_limit;
                            users[i] = 10'd1;
                            subs[i] = '0;
                            p.group_out = 6'(i);
                            found = 1'b1;
                        end
                    if (!found)
                        p.status = sgp_pkg::ST_NO_SPACE;
                end
                sgp_pkg::OP_GROUP_PUT:
                begin
                    if (!is_live(r.group_in))
                        p.status = sgp_pkg::ST_NOT_FOUND;
                    else
                    begin
                        users[r.group_in] = 10'(users[r.group_in] - 10'd1);
                        if (users[r.group_in] == 10'd0)
                            live[r.group_in] = 1'b0;
                    end
                end
                sgp_pkg::OP_SUB_GET:
                begin
                    if (is_live(r.group_in))
                    begin
                        for (int i = 0; i < NSUB && !found; i++)
                            if (!subs[r.group_in][i])
                            begin
                                subs[r.group_in][i] = 1'b1;
                                p.sub_out = 4'(i);
                                found = 1'b1;
                            end
                        if (!found)
                            p.status = sgp_pkg::ST_NO_SPACE;
                    end
                end
                default:
                begin
                    if (is_live(r.group_in))
                        subs[r.group_in][r.sub_in] = 1'b0;
                end
            endcase
            pending.push_back(p);
        endfunction

        // Compare one result word with the oldest prediction.
        function void check_result(sgp_pkg::rsp_t a);
            sgp_pkg::rsp_t e;
            if (pending.size() == 0)
            begin
                $error("result word with no request outstanding: %h", a);
                errors++;
                return;
            end
            e = pending.pop_front();
            checked++;
            if (a.status !== e.status)
            begin
                $error("status: expected %0d, actual %0d", e.status, a.status);
                errors++;
            end
            if (a.group_out !== e.group_out)
            begin
                $error("group_out: expected %0d, actual %0d", e.group_out, a.group_out);
                errors++;
            end
            if (a.sub_out !== e.sub_out)
            begin
                $error("sub_out: expected %0d, actual %0d", e.sub_out, a.sub_out);
                errors++;
            end
        endfunction
    endclass

    logic clk = 0;
    logic rst_n = 0;
    logic start = 0;
    logic busy;
    logic done;
    sgp_pkg::req_t request = '0;
    sgp_pkg::rsp_t result;

    pool_scoreboard sb = new();
    int idle_cycles = 0;
    int accepted = 0;
    bit bursty = 1;
    // Groups handed out so far, so that random puts mostly hit live IDs.
    bit [5:0] granted [$];

    always #10 clk = ~clk;

    shared_group_id_pool_with_sub_ids uut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .request(request), .done(done), .result(result)
    );

    // Monitor: the accepting edge is the one where start is high and busy
    // low; sampling at that edge reads the values held before it.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (start && !busy)
            begin
                sb.note_request(request);
                accepted++;
            end
            if (done)
            begin
                if (sb.pending.size() > 0 && sb.pending[0].group_out != 6'd0
                    && result.status == sgp_pkg::ST_OK)
                    granted.push_back(result.group_out);
                sb.check_result(result);
            end
            if ((start && !busy) || done)
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("timeout: no handshake for %0d cycles", IDLE_LIMIT);
                $display("shared_group_id_pool_with_sub_ids_test failed");
                $finish;
            end
        end
    end

    // Drive one request word and hold it until the block takes it. Start
    // stays high after the accepting edge so that words can follow directly;
    // an idle gap or a drain lowers it.
    task automatic send_word(sgp_pkg::req_t r);
        int gap;
        if (bursty && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 11);
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        request <= r;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    task automatic send_op(logic [1:0] op, int s, int l, int g, int sub);
        sgp_pkg::req_t r;
        r.op = op;
        r.service_id = 16'(s);
        r.share_limit = 10'(l);
        r.group_in = 6'(g);
        r.sub_in = 4'(sub);
        send_word(r);
    endtask

    // Stop sending and wait until every predicted word has come back.
    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (sb.pending.size() != 0)
            @(posedge clk);
    endtask

    // Random request: mostly well-aimed at live groups and few services.
    task automatic send_random();
        int g;
        int s;
        int l;
        int k;
        k = $urandom_range(0, 99);
        if (granted.size() > 0 && $urandom_range(0, 4) != 0)
            g = int'(granted[$urandom_range(0, granted.size() - 1)]);
        else
            g = $urandom_range(0, 63);
        s = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, 3);
        l = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 1023) : $urandom_range(0, 3);
        if (k < 35)
            send_op(sgp_pkg::OP_GROUP_GET, s, l, $urandom_range(0, 63),
                    $urandom_range(0, 15));
        else if (k < 60)
            send_op(sgp_pkg::OP_GROUP_PUT, $urandom_range(0, 65535),
                    $urandom_range(0, 1023), g, $urandom_range(0, 15));
        else if (k < 80)
            send_op(sgp_pkg::OP_SUB_GET, $urandom_range(0, 65535),
                    $urandom_range(0, 1023), g, $urandom_range(0, 15));
        else
            send_op(sgp_pkg::OP_SUB_PUT, $urandom_range(0, 65535),
                    $urandom_range(0, 1023), g, $urandom_range(0, 15));
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // Directed: unknown groups on put, sub-ID get and sub-ID put, including ID 0 and the top ID.
        send_op(sgp_pkg::OP_GROUP_PUT, 0, 0, 0, 0);
        send_op(sgp_pkg::OP_GROUP_PUT, 0, 0, 63, 0);
        send_op(sgp_pkg::OP_SUB_GET, 0, 0, 5, 0);
        send_op(sgp_pkg::OP_SUB_PUT, 0, 0, 5, 15);
        // Sharing with limit 2, a zero share limit, field extremes.
        send_op(sgp_pkg::OP_GROUP_GET, 65535, 2, 63, 15);
        send_op(sgp_pkg::OP_GROUP_GET, 65535, 2, 0, 0);
        send_op(sgp_pkg::OP_GROUP_GET, 65535, 2, 0, 0);
        send_op(sgp_pkg::OP_GROUP_GET, 0, 0, 0, 0);
        send_op(sgp_pkg::OP_GROUP_GET, 0, 0, 0, 0);
        send_op(sgp_pkg::OP_GROUP_GET, 0, 1023, 0, 0);
        // Fill group 1's sub-ID bitmap, then overflow it.
        for (int i = 0; i < NSUB + 1; i++)
            send_op(sgp_pkg::OP_SUB_GET, 0, 0, 1, 0);
        send_op(sgp_pkg::OP_SUB_PUT, 0, 0, 1, 7);
        send_op(sgp_pkg::OP_SUB_PUT, 0, 0, 1, 7);
        send_op(sgp_pkg::OP_SUB_GET, 0, 0, 1, 0);
        // Pause until every prediction has come back.
        drain();
        // Fill the whole pool, hit pool full, then free everything.
        for (int i = 0; i < NGRP; i++)
            send_op(sgp_pkg::OP_GROUP_GET, $urandom_range(0, 65535), 1, 0, 0);
        for (int i = 1; i < NGRP; i++)
        begin
            drain();
            while (sb.live[i])
            begin
                send_op(sgp_pkg::OP_GROUP_PUT, 0, 0, i, 0);
                drain();
            end
        end
        drain();
        granted.delete();

        // Random part; the last stretch has no idle gaps.
        for (int n = 0; n < 950; n++)
        begin
            if (n == 820)
                bursty = 0;
            if (granted.size() > 200)
                granted.delete();
            send_random();
        end

        drain();
        repeat (NGRP + 8) @(posedge clk);
        $display("covered %0d requests and %0d checked result words,",
                 accepted, sb.checked);
        $display("including pool full, sub-ID overflow and unknown groups");
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("shared_group_id_pool_with_sub_ids_test passed");
        else
            $display("shared_group_id_pool_with_sub_ids_test failed");
        $finish;
    end
endmodule

// ===== filelist.f =====
hdl/sgp_pkg.sv
hdl/sgp_ram.sv
hdl/sgp_ctrl.sv
hdl/sgp_dpath.sv
hdl/shared_group_id_pool_with_sub_ids.sv
sim/shared_group_id_pool_with_sub_ids_test.sv
